FILE: hw/rtl/ltr_pkg.sv
// shared constants, control word layout and microcode table for the link reduction block
package ltr_pkg;

    localparam int MAX_LINKS  = 32;
    localparam int CLASS_BITS = 5;
    localparam int LINK_W     = 2 * CLASS_BITS;
    localparam int ADDR_W     = $clog2(MAX_LINKS);
    localparam int CNT_W      = $clog2(MAX_LINKS + 1);
    localparam int TDATA_W    = ((LINK_W + 7) / 8) * 8;
    localparam int STEP_W     = 4;

    // read address select
    localparam logic [2:0] ASEL_NONE = 3'd0;
    localparam logic [2:0] ASEL_I    = 3'd1;
    localparam logic [2:0] ASEL_J    = 3'd2;
    localparam logic [2:0] ASEL_K    = 3'd3;
    localparam logic [2:0] ASEL_LAST = 3'd4;
    localparam logic [2:0] ASEL_O    = 3'd5;

    // branch conditions
    localparam logic [3:0] COND_ALWAYS   = 4'd0;
    localparam logic [3:0] COND_FINAL    = 4'd1;
    localparam logic [3:0] COND_I_GE_N   = 4'd2;
    localparam logic [3:0] COND_J_GE_N   = 4'd3;
    localparam logic [3:0] COND_J_SKIP   = 4'd4;
    localparam logic [3:0] COND_K_GE_N   = 4'd5;
    localparam logic [3:0] COND_BRIDGE   = 4'd6;
    localparam logic [3:0] COND_OUT_FREE = 4'd7;
    localparam logic [3:0] COND_O_DONE   = 4'd8;

    // datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_START    = 4'd1;
    localparam logic [3:0] OP_LATCH_P  = 4'd2;
    localparam logic [3:0] OP_INC_I    = 4'd3;
    localparam logic [3:0] OP_INC_J    = 4'd4;
    localparam logic [3:0] OP_LATCH_J  = 4'd5;
    localparam logic [3:0] OP_INC_K    = 4'd6;
    localparam logic [3:0] OP_DEL      = 4'd7;
    localparam logic [3:0] OP_OUT_INIT = 4'd8;
    localparam logic [3:0] OP_EMIT     = 4'd9;
    localparam logic [3:0] OP_CLEAR    = 4'd10;

    // microprogram steps
    localparam logic [STEP_W-1:0] ST_LOAD  = 4'd0;
    localparam logic [STEP_W-1:0] ST_ICHK  = 4'd1;
    localparam logic [STEP_W-1:0] ST_IRD   = 4'd2;
    localparam logic [STEP_W-1:0] ST_JCHK  = 4'd3;
    localparam logic [STEP_W-1:0] ST_JRD   = 4'd4;
    localparam logic [STEP_W-1:0] ST_KCHK  = 4'd5;
    localparam logic [STEP_W-1:0] ST_KRD   = 4'd6;
    localparam logic [STEP_W-1:0] ST_DEL   = 4'd7;
    localparam logic [STEP_W-1:0] ST_DELW  = 4'd8;
    localparam logic [STEP_W-1:0] ST_ORD   = 4'd9;
    localparam logic [STEP_W-1:0] ST_OPUT  = 4'd10;
    localparam logic [STEP_W-1:0] ST_ONEXT = 4'd11;

    typedef struct packed {
        logic [2:0]        asel;
        logic [3:0]        cond;
        logic [3:0]        op_t;
        logic [STEP_W-1:0] tgt_t;
        logic [3:0]        op_f;
        logic [STEP_W-1:0] tgt_f;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{ASEL_NONE, COND_ALWAYS, OP_NONE, ST_LOAD, OP_NONE, ST_LOAD};
        case (step)
            ST_LOAD:  w = '{ASEL_NONE, COND_FINAL,    OP_START,    ST_ICHK,
                            OP_NONE,   ST_LOAD};
            ST_ICHK:  w = '{ASEL_I,    COND_I_GE_N,   OP_OUT_INIT, ST_ORD,
                            OP_NONE,   ST_IRD};
            ST_IRD:   w = '{ASEL_NONE, COND_ALWAYS,   OP_LATCH_P,  ST_JCHK,
                            OP_NONE,   ST_JCHK};
            ST_JCHK:  w = '{ASEL_J,    COND_J_GE_N,   OP_INC_I,    ST_ICHK,
                            OP_NONE,   ST_JRD};
            ST_JRD:   w = '{ASEL_NONE, COND_J_SKIP,   OP_INC_J,    ST_JCHK,
                            OP_LATCH_J, ST_KCHK};
            ST_KCHK:  w = '{ASEL_K,    COND_K_GE_N,   OP_INC_J,    ST_JCHK,
                            OP_NONE,   ST_KRD};
            ST_KRD:   w = '{ASEL_NONE, COND_BRIDGE,   OP_NONE,     ST_DEL,
                            OP_INC_K,  ST_KCHK};
            ST_DEL:   w = '{ASEL_LAST, COND_ALWAYS,   OP_NONE,     ST_DELW,
                            OP_NONE,   ST_DELW};
            ST_DELW:  w = '{ASEL_NONE, COND_ALWAYS,   OP_DEL,      ST_ICHK,
                            OP_NONE,   ST_ICHK};
            ST_ORD:   w = '{ASEL_O,    COND_ALWAYS,   OP_NONE,     ST_OPUT,
                            OP_NONE,   ST_OPUT};
            ST_OPUT:  w = '{ASEL_O,    COND_OUT_FREE, OP_EMIT,     ST_ONEXT,
                            OP_NONE,   ST_OPUT};
            ST_ONEXT: w = '{ASEL_NONE, COND_O_DONE,   OP_CLEAR,    ST_LOAD,
                            OP_NONE,   ST_ORD};
            default:  w = '{ASEL_NONE, COND_ALWAYS,   OP_CLEAR,    ST_LOAD,
                            OP_CLEAR,  ST_LOAD};
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/ltr_ram.sv
// generic single write port, single read port ram with registered read
module ltr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/link_transitive_reduction_top.sv
// link transitive reduction top level: link store, microcoded sequencer and output register
//
// Links are taken one per cycle while the block is loading. The item with tlast set ends the
// set: the block then stops taking items and removes every link A->C that is bridged by two
// other links A->B and B->C, scanning positions in order and refilling a removed position
// with the current last link. Every memory read goes through the single read port of the
// link ram and every step is one control word of the microprogram, so checking one position
// reads every link of the set in turn to find the others that share its source, and for each
// of them reads the set again to find a bridging link; a removal reads the current last link
// and writes it back in place of the removed one.
// Survivors then leave one at a time, each read from the link ram and registered once the
// output register is free, the last one with tlast set, and loading resumes after it has been
// registered. A link that arrives while 32 links are held is dropped.
module link_transitive_reduction_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // link_source, link_target, zero pad
    input  logic        s_tlast,   // final_link
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // kept_source, kept_target, zero pad
    output logic        m_tlast    // last_kept
);

    localparam int CB = ltr_pkg::CLASS_BITS;
    localparam int CW = ltr_pkg::CNT_W;
    localparam int AW = ltr_pkg::ADDR_W;

    logic [ltr_pkg::STEP_W-1:0] step_reg, step_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              i_reg, i_next;
    logic [CW-1:0]              j_reg, j_next;
    logic [CW-1:0]              k_reg, k_next;
    logic [CW-1:0]              o_reg, o_next;
    logic [CB-1:0]              src_p_reg, src_p_next;
    logic [CB-1:0]              dst_p_reg, dst_p_next;
    logic [CB-1:0]              dst_j_reg, dst_j_next;
    logic                       out_valid_reg, out_valid_next;
    logic [ltr_pkg::LINK_W-1:0] out_data_reg, out_data_next;
    logic                       out_last_reg, out_last_next;

    ltr_pkg::ucode_t            uw;
    logic                       cond;
    logic [3:0]                 op;
    logic                       accept;
    logic                       load_we;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [ltr_pkg::LINK_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [ltr_pkg::LINK_W-1:0] ram_rdata;
    logic [CB-1:0]              rd_src;
    logic [CB-1:0]              rd_dst;
    logic [CW-1:0]              last_pos;

    assign uw       = ltr_pkg::ucode_rom(step_reg);
    assign s_tready = (step_reg == ltr_pkg::ST_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign load_we  = accept && (count_reg < CW'(ltr_pkg::MAX_LINKS));
    assign rd_src   = ram_rdata[CB-1:0];
    assign rd_dst   = ram_rdata[2*CB-1:CB];
    assign last_pos = count_reg - CW'(1);

    always_comb
    begin
        case (uw.cond)
            ltr_pkg::COND_ALWAYS:   cond = 1'b1;
            ltr_pkg::COND_FINAL:    cond = accept && s_tlast;
            ltr_pkg::COND_I_GE_N:   cond = (i_reg >= count_reg);
            ltr_pkg::COND_J_GE_N:   cond = (j_reg >= count_reg);
            ltr_pkg::COND_J_SKIP:   cond = (j_reg == i_reg) || (rd_src != src_p_reg);
            ltr_pkg::COND_K_GE_N:   cond = (k_reg >= count_reg);
            ltr_pkg::COND_BRIDGE:   cond = (k_reg != j_reg) && (k_reg != i_reg)
                                        && (rd_src == dst_j_reg) && (rd_dst == dst_p_reg);
            ltr_pkg::COND_OUT_FREE: cond = !out_valid_reg || m_tready;
            ltr_pkg::COND_O_DONE:   cond = (o_reg >= count_reg);
            default:                cond = 1'b1;
        endcase
    end

    assign op        = cond ? uw.op_t : uw.op_f;
    assign step_next = cond ? uw.tgt_t : uw.tgt_f;

    always_comb
    begin
        case (uw.asel)
            ltr_pkg::ASEL_I:    ram_raddr = i_reg[AW-1:0];
            ltr_pkg::ASEL_J:    ram_raddr = j_reg[AW-1:0];
            ltr_pkg::ASEL_K:    ram_raddr = k_reg[AW-1:0];
            ltr_pkg::ASEL_LAST: ram_raddr = last_pos[AW-1:0];
            ltr_pkg::ASEL_O:    ram_raddr = o_reg[AW-1:0];
            default:            ram_raddr = '0;
        endcase
    end

    always_comb
    begin
        ram_we    = load_we;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = {s_tdata[2*CB-1:CB], s_tdata[CB-1:0]};
        if (op == ltr_pkg::OP_DEL)
        begin
            ram_we    = 1'b1;
            ram_waddr = i_reg[AW-1:0];
            ram_wdata = ram_rdata;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        o_next         = o_reg;
        src_p_next     = src_p_reg;
        dst_p_next     = dst_p_reg;
        dst_j_next     = dst_j_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (load_we)
        begin
            count_next = count_reg + CW'(1);
        end
        case (op)
            ltr_pkg::OP_START:    i_next = '0;
            ltr_pkg::OP_LATCH_P:
            begin
                src_p_next = rd_src;
                dst_p_next = rd_dst;
                j_next     = '0;
            end
            ltr_pkg::OP_INC_I:    i_next = i_reg + CW'(1);
            ltr_pkg::OP_INC_J:    j_next = j_reg + CW'(1);
            ltr_pkg::OP_LATCH_J:
            begin
                dst_j_next = rd_dst;
                k_next     = '0;
            end
            ltr_pkg::OP_INC_K:    k_next = k_reg + CW'(1);
            ltr_pkg::OP_DEL:      count_next = count_reg - CW'(1);
            ltr_pkg::OP_OUT_INIT: o_next = '0;
            ltr_pkg::OP_EMIT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = ram_rdata;
                out_last_next  = (o_reg == last_pos);
                o_next         = o_reg + CW'(1);
            end
            ltr_pkg::OP_CLEAR:    count_next = '0;
            default:              count_next = count_next;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ltr_pkg::ST_LOAD;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            o_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            o_reg         <= o_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_p_reg    <= src_p_next;
        dst_p_reg    <= dst_p_next;
        dst_j_reg    <= dst_j_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    ltr_ram #(
        .WIDTH(ltr_pkg::LINK_W),
        .DEPTH(ltr_pkg::MAX_LINKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ltr_pkg::TDATA_W - ltr_pkg::LINK_W){1'b0}}, out_data_reg};
    assign m_tlast  = out_last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ltr_pkg::MAX_LINKS))
        else $error("link count above capacity");

    a_del_needs_three: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ltr_pkg::ST_DELW) |-> (count_reg > CW'(2)))
        else $error("removal with fewer than three links");

    a_scan_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != ltr_pkg::ST_LOAD) |-> (i_reg <= count_reg))
        else $error("scan position beyond link count");

    a_emit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (op == ltr_pkg::OP_EMIT) |-> (o_reg < count_reg))
        else $error("emit beyond surviving links");

endmodule
